### rtl/core/rc_ack_retransmit_tracker_core_defines.svh
// Assertion macros for the RC ACK and retransmit tracker
`ifndef RC_ACK_RETRANSMIT_TRACKER_CORE_DEFINES_SVH
`define RC_ACK_RETRANSMIT_TRACKER_CORE_DEFINES_SVH

// same-cycle implication
`define RAT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker check failed");

// next-cycle implication
`define RAT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker check failed");

`endif

### rtl/core/rat_pkg.sv
// Types, constants and codes shared by the tracker modules
package rat_pkg;

   localparam int PendingDepth = 16;
   localparam int SlotWidth = $clog2(PendingDepth);
   localparam int CountWidth = $clog2(PendingDepth + 1);
   localparam int PsnWidth = 24;
   localparam logic [4:0] TimeoutExpReset = 5'd14;
   localparam logic [2:0] RetryLimitReset = 3'd7;
   localparam logic [63:0] TimeoutBase = 64'd4;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_ACK,
      KIND_ADVANCE,
      KIND_CHECK
   } kind_type;

   typedef enum logic [1:0] {
      SYN_ACK,
      SYN_RNR,
      SYN_SEQ_ERR,
      SYN_OTHER
   } syndrome_type;

   typedef enum logic [1:0] {
      EVT_NONE,
      EVT_REMOTE_FATAL,
      EVT_RETRY_EXHAUSTED
   } error_event_type;

   typedef enum logic [0:0] {
      CSR_TIMEOUT_EXP,
      CSR_RETRY_LIMIT
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACK_WALK,
      ST_TIMEOUT_WALK,
      ST_RESULT
   } state_type;

   typedef enum logic [0:0] {
      EVAL_ACK_WINDOW,
      EVAL_TIMEOUT
   } eval_mode_type;

   typedef struct packed {
      eval_mode_type mode;
      logic [63:0]   a;
      logic [63:0]   b;
      logic [63:0]   thresh;
   } eval_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] wqe_tag;
      logic [23:0] start_psn;
      logic [15:0] packet_count;
      logic [23:0] ack_psn;
      logic [1:0]  syndrome;
      logic [31:0] advance_us;
      logic [63:0] now_us;
   } req_payload_type;

   typedef struct packed {
      logic        retransmit_valid;
      logic [15:0] retransmit_tag;
      logic        last_of_run;
      logic [4:0]  retired_now;
      logic        qp_in_error;
      logic [4:0]  pending_count;
      logic        add_rejected;
      logic [31:0] total_completions;
      logic [31:0] total_retransmits;
      logic [31:0] rnr_nak_total;
      logic [31:0] seq_error_total;
      logic [1:0]  error_event;
   } rsp_payload_type;

endpackage

### rtl/core/rat_eval.sv
// Shared subtract-and-compare unit for the ACK window and timeout walks
module rat_eval import rat_pkg::*; (
   input  eval_req_type eval_req,
   output logic         hit
);

   logic [63:0] diff;

   assign diff = eval_req.a - eval_req.b;

   always_comb begin
      case (eval_req.mode)
         EVAL_ACK_WINDOW: hit = (diff[PsnWidth-1:0] <= eval_req.thresh[PsnWidth-1:0]);
         EVAL_TIMEOUT:    hit = (diff >= eval_req.thresh);
         default:         hit = 1'b0;
      endcase
   end

endmodule

### rtl/core/rc_ack_retransmit_tracker_core.sv
// Add, NAK and time advance give their result in the cycle after the transfer.
// A positive ACK walks one queue entry a cycle, then gives its result.
// A timeout check walks one entry a cycle, stopping early when an entry runs out of
// retries, then gives one result per cycle while not stalled.
// No new item is accepted until the current one's walk and results are done.
// Reset: synchronous; clears queue control, counters and clock, config to 14 and 7.
module rc_ack_retransmit_tracker_core import rat_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   state_type state_ff, state_in;

   logic [15:0] tag_ff     [PendingDepth];
   logic [23:0] first_ff   [PendingDepth];
   logic [15:0] packets_ff [PendingDepth];
   logic [63:0] stamp_ff   [PendingDepth];
   logic [2:0]  retries_ff [PendingDepth];
   logic [15:0] rtag_ff    [PendingDepth];

   logic [SlotWidth-1:0]  head_ff;
   logic [CountWidth-1:0] count_ff;
   logic [23:0]           last_acked_ff;
   logic [63:0]           local_time_ff;
   logic                  error_ff;
   logic [31:0]           completions_ff;
   logic [31:0]           retransmits_ff;
   logic [31:0]           rnr_ff;
   logic [31:0]           seqerr_ff;
   logic [4:0]            exp_ff;
   logic [2:0]            retry_ff;
   logic [23:0]           acked_ff;
   logic [23:0]           span_ff;
   logic [63:0]           now_ff;
   logic [CountWidth-1:0] walk_ff;
   logic [CountWidth-1:0] ntag_ff;
   logic [SlotWidth-1:0]  emit_ff;
   logic [4:0]            retired_ff;
   logic                  rejected_ff;
   error_event_type       event_ff;

   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  csr_write;
   logic [SlotWidth-1:0]  slot;
   logic [SlotWidth-1:0]  tail;
   logic [23:0]           last_psn;
   logic                  hit;
   logic                  ack_done;
   logic                  walk_end;
   logic                  exhausted;
   logic                  last_result;
   eval_req_type          eval_req;
   kind_type              kind;
   syndrome_type          syndrome;

   assign kind      = kind_type'(req_data.kind);
   assign syndrome  = syndrome_type'(req_data.syndrome);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign slot      = head_ff + walk_ff[SlotWidth-1:0];
   assign tail      = head_ff + count_ff[SlotWidth-1:0];
   assign last_psn  = first_ff[slot] + {8'd0, packets_ff[slot]} - 24'd1;

   always_comb begin
      if (state_ff == ST_ACK_WALK) begin
         eval_req.mode   = EVAL_ACK_WINDOW;
         eval_req.a      = {40'd0, last_psn};
         eval_req.b      = {40'd0, last_acked_ff};
         eval_req.thresh = {40'd0, span_ff};
      end else begin
         eval_req.mode   = EVAL_TIMEOUT;
         eval_req.a      = now_ff;
         eval_req.b      = stamp_ff[slot];
         eval_req.thresh = TimeoutBase << exp_ff;
      end
   end

   rat_eval u_eval (
      .eval_req (eval_req),
      .hit      (hit)
   );

   assign ack_done    = (count_ff == '0) || !hit;
   assign walk_end    = (walk_ff == count_ff);
   assign exhausted   = !walk_end && hit && (retries_ff[slot] == 3'd0);
   assign last_result = (ntag_ff == '0)
                        || ({1'b0, emit_ff} + CountWidth'(1) == ntag_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (kind == KIND_ACK && syndrome == SYN_ACK) begin
                  state_in = ST_ACK_WALK;
               end else if (kind == KIND_CHECK) begin
                  state_in = ST_TIMEOUT_WALK;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_ACK_WALK: begin
            if (ack_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_TIMEOUT_WALK: begin
            if (walk_end || exhausted) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_xfer && last_result) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESULT);
      rsp_data.retransmit_valid  = (ntag_ff != '0);
      rsp_data.retransmit_tag    = (ntag_ff != '0) ? rtag_ff[emit_ff] : 16'd0;
      rsp_data.last_of_run       = last_result;
      rsp_data.retired_now       = retired_ff;
      rsp_data.qp_in_error       = error_ff;
      rsp_data.pending_count     = 5'(count_ff);
      rsp_data.add_rejected      = rejected_ff;
      rsp_data.total_completions = completions_ff;
      rsp_data.total_retransmits = retransmits_ff;
      rsp_data.rnr_nak_total     = rnr_ff;
      rsp_data.seq_error_total   = seqerr_ff;
      rsp_data.error_event       = event_ff;
   end

   always_comb begin
      case (csr_index_type'(csr_paddr[2]))
         CSR_TIMEOUT_EXP: csr_prdata = {27'd0, exp_ff};
         CSR_RETRY_LIMIT: csr_prdata = {29'd0, retry_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         last_acked_ff  <= '0;
         local_time_ff  <= '0;
         error_ff       <= 1'b0;
         completions_ff <= '0;
         retransmits_ff <= '0;
         rnr_ff         <= '0;
         seqerr_ff      <= '0;
         exp_ff         <= TimeoutExpReset;
         retry_ff       <= RetryLimitReset;
         ntag_ff        <= '0;
         emit_ff        <= '0;
         walk_ff        <= '0;
         retired_ff     <= '0;
         rejected_ff    <= 1'b0;
         event_ff       <= EVT_NONE;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_index_type'(csr_paddr[2]))
               CSR_TIMEOUT_EXP: exp_ff <= csr_pwdata[4:0];
               CSR_RETRY_LIMIT: retry_ff <= csr_pwdata[2:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  retired_ff  <= '0;
                  rejected_ff <= 1'b0;
                  event_ff    <= EVT_NONE;
                  ntag_ff     <= '0;
                  emit_ff     <= '0;
                  walk_ff     <= '0;
                  case (kind)
                     KIND_ADD: begin
                        if (count_ff == CountWidth'(PendingDepth)) begin
                           rejected_ff <= 1'b1;
                        end else begin
                           tag_ff[tail]     <= req_data.wqe_tag;
                           first_ff[tail]   <= req_data.start_psn;
                           packets_ff[tail] <= req_data.packet_count;
                           stamp_ff[tail]   <= local_time_ff;
                           retries_ff[tail] <= retry_ff;
                           count_ff         <= count_ff + CountWidth'(1);
                        end
                     end
                     KIND_ACK: begin
                        acked_ff <= req_data.ack_psn;
                        span_ff  <= req_data.ack_psn - last_acked_ff;
                        case (syndrome)
                           SYN_ACK: ;
                           SYN_RNR: rnr_ff <= rnr_ff + 32'd1;
                           SYN_SEQ_ERR: begin
                              seqerr_ff      <= seqerr_ff + 32'd1;
                              retransmits_ff <= retransmits_ff + 32'd1;
                           end
                           default: begin
                              error_ff <= 1'b1;
                              event_ff <= EVT_REMOTE_FATAL;
                           end
                        endcase
                     end
                     KIND_ADVANCE: begin
                        local_time_ff <= local_time_ff + {32'd0, req_data.advance_us};
                     end
                     default: now_ff <= req_data.now_us;
                  endcase
               end
            end
            ST_ACK_WALK: begin
               if (ack_done) begin
                  last_acked_ff <= acked_ff;
               end else begin
                  head_ff        <= head_ff + SlotWidth'(1);
                  count_ff       <= count_ff - CountWidth'(1);
                  completions_ff <= completions_ff + 32'd1;
                  retired_ff     <= retired_ff + 5'd1;
               end
            end
            ST_TIMEOUT_WALK: begin
               if (!walk_end) begin
                  walk_ff <= walk_ff + CountWidth'(1);
                  if (hit) begin
                     if (retries_ff[slot] != 3'd0) begin
                        retries_ff[slot]              <= retries_ff[slot] - 3'd1;
                        stamp_ff[slot]                <= now_ff;
                        rtag_ff[ntag_ff[SlotWidth-1:0]] <= tag_ff[slot];
                        ntag_ff                       <= ntag_ff + CountWidth'(1);
                        retransmits_ff                <= retransmits_ff + 32'd1;
                     end else begin
                        error_ff <= 1'b1;
                        event_ff <= EVT_RETRY_EXHAUSTED;
                     end
                  end
               end
            end
            ST_RESULT: begin
               if (rsp_xfer && !last_result) begin
                  emit_ff <= emit_ff + SlotWidth'(1);
               end
            end
            default: ;
         endcase
      end
   end

endmodule

### rtl/core/rat_checker.sv
// Port-level checks for the tracker, bound to the top level
`include "rc_ack_retransmit_tracker_core_defines.svh"

module rat_checker import rat_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   `RAT_ASSERT_SAME(a_busy_while_result, clock, reset, rsp_valid, req_stall)
   `RAT_ASSERT_NEXT(a_run_continues, clock, reset,
      rsp_valid && !rsp_stall && !rsp_data.last_of_run, rsp_valid)
   `RAT_ASSERT_SAME(a_plain_result_single, clock, reset,
      rsp_valid && !rsp_data.retransmit_valid,
      rsp_data.last_of_run && rsp_data.retransmit_tag == 16'd0)
   `RAT_ASSERT_NEXT(a_stalled_result_holds, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind rc_ack_retransmit_tracker_core rat_checker u_rat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
